>>> rtl/edge_aware_box_blur_defines.svh
// Assertion macros of the box blur RTL.
`ifndef EDGE_AWARE_BOX_BLUR_DEFINES_SVH
`define EDGE_AWARE_BOX_BLUR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EABB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EABB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/eabb_pkg.sv
// Types, constants and the reciprocal table of the box blur.
`default_nettype none

package eabb_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RST = 11'd480;

  // Datapath widths
  localparam int CH_W        = 8;   // one colour channel
  localparam int CSUM_W      = 10;  // sum over one window column
  localparam int SUM_W       = 12;  // sum over the whole window
  localparam int CCNT_W      = 2;   // neighbours counted in one column
  localparam int CNT_W       = 4;   // neighbours counted in the window
  localparam int NUM_W       = 13;  // 2*sum + n
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = NUM_W + RECIP_W;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // One window column, top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_pix_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
    logic [CCNT_W-1:0] cnt;
  } col_sum_t;

  // Control from the sequencer to every window cell
  typedef struct packed {
    logic shift;
    logic sum_en;
    logic top_en;
    logic bot_en;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_ADD,
    ST_MUL,
    ST_OUT
  } state_t;

  // ceil(2^RECIP_SHIFT / (2n)); exact for every numerator below 2^NUM_W
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd5:    m = 20'd104858;
      4'd6:    m = 20'd87382;
      4'd7:    m = 20'd74899;
      4'd8:    m = 20'd65536;
      4'd9:    m = 20'd58255;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/eabb_line_store.sv
// Line store memory: upper and middle rows side by side in one word.
`default_nettype none

module eabb_line_store import eabb_pkg::*; #(
  parameter int DEPTH  = MAX_WIDTH_DEF,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      col_pix_t          rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire col_pix_t          wr_data
);

  col_pix_t mem [DEPTH];
  col_pix_t rd_data_r;

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/eabb_col_cell.sv
// Window cell: holds one column of three pixels and sums its in-frame part.
`default_nettype none

module eabb_col_cell import eabb_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      col_en,
  input  wire col_pix_t  shift_in,
  output      col_pix_t  col_out,
  output      col_sum_t  sum_out
);

  col_pix_t col_r;
  col_sum_t sum_r;
  col_sum_t sum_nxt;

  // Take the column of the right-hand neighbour
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= shift_in;
    end
  end

  // Masked column sum; the middle row is always in frame
  always_comb begin
    sum_nxt.red   = CSUM_W'(col_r.mid.red)
                  + (ctl.top_en ? CSUM_W'(col_r.top.red)   : '0)
                  + (ctl.bot_en ? CSUM_W'(col_r.bot.red)   : '0);
    sum_nxt.green = CSUM_W'(col_r.mid.green)
                  + (ctl.top_en ? CSUM_W'(col_r.top.green) : '0)
                  + (ctl.bot_en ? CSUM_W'(col_r.bot.green) : '0);
    sum_nxt.blue  = CSUM_W'(col_r.mid.blue)
                  + (ctl.top_en ? CSUM_W'(col_r.top.blue)  : '0)
                  + (ctl.bot_en ? CSUM_W'(col_r.bot.blue)  : '0);
    sum_nxt.cnt   = CCNT_W'(1) + CCNT_W'(ctl.top_en) + CCNT_W'(ctl.bot_en);
    if (!col_en) begin
      sum_nxt = '0;
    end
  end

  // Hold the sum for the adder stage
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum_out = sum_r;

endmodule

`default_nettype wire

>>> rtl/eabb_mean.sv
// Rounded mean of one colour: (2*sum + n) / (2n) by reciprocal multiply.
`default_nettype none

module eabb_mean import eabb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             load_en,
  input  wire logic             mul_en,
  input  wire logic [SUM_W-1:0] sum_in,
  input  wire logic [CNT_W-1:0] cnt_in,
  output      logic [CH_W-1:0]  mean_out
);

  logic [NUM_W-1:0]   num_r;
  logic [RECIP_W-1:0] recip_r;
  logic [PROD_W-1:0]  prod_r;

  // Form the numerator and look up the reciprocal of the divisor
  always_ff @(posedge clk) begin
    if (load_en) begin
      num_r   <= {sum_in, 1'b0} + NUM_W'(cnt_in);
      recip_r <= recip(cnt_in);
    end
  end

  // Multiply; the quotient sits above the fraction bits
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(num_r) * PROD_W'(recip_r);
    end
  end

  assign mean_out = prod_r[RECIP_SHIFT +: CH_W];

endmodule

`default_nettype wire

>>> rtl/edge_aware_box_blur.sv
// Streaming 3x3 box blur of RGB pixels: sequencer, counters and output register.
//
// Input channel (in_valid/in_stall): one pixel per transfer in raster order, or a
// drain item (in_cmd = 1) once the whole frame has arrived. An early drain is taken
// and dropped. Output channel (out_valid/out_stall): one blurred pixel per transfer,
// out_frame_last marking the last pixel of the frame.
// Configuration (cfg_wr_en/cfg_index/cfg_wdata): frame width and height, written
// while idle; any write to either register restarts the frame.
// Output pixel k of a frame comes out for the input item at position k + W + 1, so
// W + 1 drain items flush the frame end.
// Timing: the transfer edge reads the line store; shift, column sum, add, multiply
// and output load follow in states READ, SUM, ADD, MUL and OUT, the load waiting
// while the output is held. The next item is taken in the load cycle, so no item
// is taken before the last result loads. An item without a result goes idle after
// READ. A single sequencer runs each item through line store read and mean multiplier.
// Reset (synchronous, rst_n low): counters to frame start, 640 x 480 frame,
// output empty. Line store contents are never used before they are written.
// When the receiver stalls, the result waits in the output register; the input
// stalls in states READ to MUL, and in OUT until the next result can load.
`default_nettype none
`include "edge_aware_box_blur_defines.svh"

module edge_aware_box_blur import eabb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 in_cmd,
  input  wire logic [CH_W-1:0]      in_red,
  input  wire logic [CH_W-1:0]      in_green,
  input  wire logic [CH_W-1:0]      in_blue,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [CH_W-1:0]      out_red,
  output      logic [CH_W-1:0]      out_green,
  output      logic [CH_W-1:0]      out_blue,
  output      logic                 out_frame_last,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_width_r, cfg_width_nxt;
  logic [CFG_W-1:0] cfg_height_r, cfg_height_nxt;
  logic [WW-1:0]    w_cur;
  logic [HW-1:0]    h_cur;

  logic [AW-1:0]    in_col_r, in_col_nxt;
  logic [RW-1:0]    in_row_r, in_row_nxt;
  logic [AW-1:0]    out_col_r, out_col_nxt;
  logic [ORW-1:0]   out_row_r, out_row_nxt;

  // per-item registers, loaded on a taken transfer
  pixel_t           pix_r;
  logic [AW-1:0]    addr_r;
  logic             emit_r;
  logic             last_r;
  logic             top_en_r, bot_en_r, left_en_r, right_en_r;

  logic             in_fire, in_done, in_take, acc_ok, out_free, out_load;
  logic             emit_now, last_now, top_now, bot_now, left_now, right_now;
  pixel_t           pix_now;

  col_pix_t         rd_data, new_col, wr_col;
  col_pix_t         col_out0, col_out1, col_out2;
  col_sum_t         sum0, sum1, sum2;
  cell_ctl_t        cell_ctl;
  logic [SUM_W-1:0] tot_red, tot_green, tot_blue;
  logic [CNT_W-1:0] tot_cnt;
  logic [CH_W-1:0]  mean_red, mean_green, mean_blue;

  logic             out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic             out_last_r;

  // Clamp the frame size to 1..MAX
  always_comb begin
    if (cfg_width_r == '0) begin
      w_cur = WW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_cur = WW'(MAX_WIDTH);
    end else begin
      w_cur = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_cur = HW'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      h_cur = HW'(MAX_HEIGHT);
    end else begin
      h_cur = HW'(cfg_height_r);
    end
  end

  // Handshake and classification of the incoming item
  assign out_free  = !out_valid_r || !out_stall;
  assign acc_ok    = (state_r == ST_IDLE) || ((state_r == ST_OUT) && out_free);
  assign in_stall  = !acc_ok;
  assign in_fire   = in_valid && acc_ok;
  assign in_done   = 32'(in_row_r) >= 32'(h_cur);
  assign in_take   = in_fire && !(in_cmd && !in_done);
  assign pix_now   = (!in_cmd && !in_done) ? pixel_t'({in_red, in_green, in_blue}) : '0;

  // A result exists once position W + 1 is reached
  assign emit_now  = (32'(in_row_r) >= 32'd2) || ((32'(in_row_r) == 32'd1) && (in_col_r != '0));
  assign top_now   = out_row_r != '0;
  assign bot_now   = (32'(out_row_r) + 32'd1) < 32'(h_cur);
  assign left_now  = out_col_r != '0;
  assign right_now = (32'(out_col_r) + 32'd1) < 32'(w_cur);
  assign last_now  = !bot_now && !right_now;

  // Configuration decode and stream position
  always_comb begin
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    if (in_take) begin
      if ((32'(in_col_r) + 32'd1) >= 32'(w_cur)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + AW'(1);
      end
      if (emit_now) begin
        if (last_now) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (!right_now) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ORW'(1);
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end
    end
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          cfg_width_nxt = cfg_wdata;
          in_col_nxt    = '0;
          in_row_nxt    = '0;
          out_col_nxt   = '0;
          out_row_nxt   = '0;
        end
        REG_FRAME_HEIGHT: begin
          cfg_height_nxt = cfg_wdata;
          in_col_nxt     = '0;
          in_row_nxt     = '0;
          out_col_nxt    = '0;
          out_row_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= FRAME_WIDTH_RST;
      cfg_height_r <= FRAME_HEIGHT_RST;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
    end else begin
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
    end
  end

  // Capture the taken item
  always_ff @(posedge clk) begin
    if (in_take) begin
      pix_r      <= pix_now;
      addr_r     <= in_col_r;
      emit_r     <= emit_now;
      last_r     <= last_now;
      top_en_r   <= top_now;
      bot_en_r   <= bot_now;
      left_en_r  <= left_now;
      right_en_r <= right_now;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = emit_r ? ST_SUM : ST_IDLE;
      ST_SUM:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = in_take ? ST_READ : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Line stores: read the column on transfer, rotate rows up in the next cycle
  eabb_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (in_col_r),
    .rd_data (rd_data),
    .wr_en   (state_r == ST_READ),
    .wr_addr (addr_r),
    .wr_data (wr_col)
  );

  // rd_data.mid holds the upper row, rd_data.bot the middle row
  assign new_col = '{top: rd_data.mid, mid: rd_data.bot, bot: pix_r};
  assign wr_col  = '{top: '0, mid: rd_data.bot, bot: pix_r};

  // Window: three cells, data moving right to left
  assign cell_ctl = '{shift:  (state_r == ST_READ),
                      sum_en: (state_r == ST_SUM),
                      top_en: top_en_r,
                      bot_en: bot_en_r};

  eabb_col_cell u_cell_right (
    .clk      (clk),
    .ctl      (cell_ctl),
    .col_en   (right_en_r),
    .shift_in (new_col),
    .col_out  (col_out2),
    .sum_out  (sum2)
  );

  eabb_col_cell u_cell_mid (
    .clk      (clk),
    .ctl      (cell_ctl),
    .col_en   (1'b1),
    .shift_in (col_out2),
    .col_out  (col_out1),
    .sum_out  (sum1)
  );

  eabb_col_cell u_cell_left (
    .clk      (clk),
    .ctl      (cell_ctl),
    .col_en   (left_en_r),
    .shift_in (col_out1),
    .col_out  (col_out0),
    .sum_out  (sum0)
  );

  // Add the column sums
  assign tot_red   = SUM_W'(sum0.red)   + SUM_W'(sum1.red)   + SUM_W'(sum2.red);
  assign tot_green = SUM_W'(sum0.green) + SUM_W'(sum1.green) + SUM_W'(sum2.green);
  assign tot_blue  = SUM_W'(sum0.blue)  + SUM_W'(sum1.blue)  + SUM_W'(sum2.blue);
  assign tot_cnt   = CNT_W'(sum0.cnt)   + CNT_W'(sum1.cnt)   + CNT_W'(sum2.cnt);

  eabb_mean u_mean_red (
    .clk      (clk),
    .load_en  (state_r == ST_ADD),
    .mul_en   (state_r == ST_MUL),
    .sum_in   (tot_red),
    .cnt_in   (tot_cnt),
    .mean_out (mean_red)
  );

  eabb_mean u_mean_green (
    .clk      (clk),
    .load_en  (state_r == ST_ADD),
    .mul_en   (state_r == ST_MUL),
    .sum_in   (tot_green),
    .cnt_in   (tot_cnt),
    .mean_out (mean_green)
  );

  eabb_mean u_mean_blue (
    .clk      (clk),
    .load_en  (state_r == ST_ADD),
    .mul_en   (state_r == ST_MUL),
    .sum_in   (tot_blue),
    .cnt_in   (tot_cnt),
    .mean_out (mean_blue)
  );

  // Output register: hold while stalled, drop once transferred
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= mean_red;
      out_green_r <= mean_green;
      out_blue_r  <= mean_blue;
      out_last_r  <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_frame_last = out_last_r;

  `EABB_ASSERT_NEXT(a_take_reads, in_take, state_r == ST_READ, "taken item did not start a read")
  `EABB_ASSERT_IMPLY(a_sum_emits, state_r == ST_SUM, emit_r, "window summed without a result")
  `EABB_ASSERT_IMPLY(a_cnt_nonzero, state_r == ST_ADD, tot_cnt != '0, "empty neighbourhood")
  `EABB_ASSERT_NEXT(a_last_restart, in_take && emit_now && last_now && !cfg_wr_en, (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0), "frame end did not restart")

endmodule

`default_nettype wire

>>> sim/tb_edge_aware_box_blur.sv
// Self-checking testbench for the streaming 3x3 box blur: directed and random frames against a built-in predictor.
module tb_edge_aware_box_blur import eabb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 4;
  localparam int LINE_LEN     = MAX_WIDTH_DEF;
  localparam int FRAME_ROWS   = MAX_HEIGHT_DEF;
  localparam int QUIET_CYCLES = 10;
  localparam int TAIL_CYCLES  = 20;
  localparam int PIXEL_TARGET = 600;
  localparam int REPORT_LIMIT = 10;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  // register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {OP_TRANSFER, OP_REG_WRITE, OP_SETTLE} op_kind_t;
  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_NEAR_EDGE} fill_t;

  typedef struct {
    op_kind_t              kind;
    logic                  cmd;
    pixel_t                px;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
  } stim_op_t;

  typedef struct {
    pixel_t px;
    logic   last;
  } blur_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_PIXEL;
  logic [CH_W-1:0]      in_red = '0;
  logic [CH_W-1:0]      in_green = '0;
  logic [CH_W-1:0]      in_blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;
  logic                 out_frame_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  stim_op_t stim_q[$];
  blur_px_t blur_q[$];
  int mismatches = 0;
  int quiet = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_run = 0;
  bit stall_now = 1'b0;

  // predictor state
  pixel_t           upper_line[LINE_LEN] = '{default: '0};
  pixel_t           middle_line[LINE_LEN] = '{default: '0};
  pixel_t           win[3][3] = '{default: '0};
  int unsigned      in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  logic [CFG_W-1:0] width_reg = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;

  edge_aware_box_blur u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // mean with halves rounded up
  function automatic logic [CH_W-1:0] round_mean(int unsigned s, int unsigned n);
    return CH_W'((2 * s + n) / (2 * n));
  endfunction

  // Advance the blur state by one item and queue the pixel it releases, if any.
  task automatic blur_predict(input logic cmd, input pixel_t px_in);
    int unsigned w, h, pos, c, n, sr, sg, sb;
    bit          input_done, last;
    pixel_t      fresh, up, mid, p;
    blur_px_t    res;
    w = clamp_dim(width_reg, LINE_LEN);
    h = clamp_dim(height_reg, FRAME_ROWS);
    input_done = (in_row >= h);
    // drop a drain that comes before the frame is in
    if (cmd == CMD_DRAIN && !input_done) return;
    fresh = input_done ? pixel_t'('0) : px_in;
    pos = in_row * w + in_col;
    c = (in_col >= LINE_LEN) ? LINE_LEN - 1 : in_col;
    // rotate the line stores at this column
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = fresh;
    // shift the window left and bring in the new column
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = up;
    win[2][1] = mid;
    win[2][2] = fresh;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < w + 1) return;
    // sum the neighbours that lie inside the frame
    n = 0;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr < 0 && out_row == 0) continue;
        if (dr > 0 && out_row + 1 >= h) continue;
        if (dc < 0 && out_col == 0) continue;
        if (dc > 0 && out_col + 1 >= w) continue;
        p = win[dc + 1][dr + 1];
        sr += p.red;
        sg += p.green;
        sb += p.blue;
        n++;
      end
    end
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.px.red = round_mean(sr, n);
    res.px.green = round_mean(sg, n);
    res.px.blue = round_mean(sb, n);
    res.last = last;
    blur_q.push_back(res);
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  function automatic pixel_t pick_pixel(fill_t fill);
    pixel_t p;
    case (fill)
      FILL_EXTREME: begin
        p.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      FILL_NEAR_EDGE: begin
        p.red = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
        p.green = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
        p.blue = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
      end
      default: p = pixel_t'($urandom);
    endcase
    return p;
  endfunction

  task automatic push_xfer(input logic cmd, input pixel_t p);
    stim_q.push_back('{OP_TRANSFER, cmd, p, '0, '0});
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    stim_q.push_back('{OP_REG_WRITE, CMD_PIXEL, '0, idx, data});
  endtask

  task automatic push_settle();
    stim_q.push_back('{OP_SETTLE, CMD_PIXEL, '0, '0, '0});
  endtask

  // One whole frame: size writes, the pixels, then W + 1 flush items.
  // A noisy frame adds drains among the pixels, a mid-frame pause, at times a
  // spare-index write, and pixels in place of some flush drains.
  task automatic push_frame(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                            input fill_t fill, input bit noisy, inout int count);
    int unsigned w, h, pause_pos;
    w = clamp_dim(wv, LINE_LEN);
    h = clamp_dim(hv, FRAME_ROWS);
    pause_pos = $urandom_range(0, w * h - 1);
    push_write(REG_FRAME_WIDTH, wv);
    push_write(REG_FRAME_HEIGHT, hv);
    for (int unsigned i = 0; i < w * h; i++) begin
      push_xfer(CMD_PIXEL, pick_pixel(fill));
      if (noisy && $urandom_range(0, 5) == 0) push_xfer(CMD_DRAIN, pixel_t'($urandom));
      if (noisy && i == pause_pos) begin
        push_settle();
        if ($urandom_range(0, 1))
          push_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
      end
    end
    for (int unsigned i = 0; i <= w; i++)
      push_xfer((noisy && $urandom_range(0, 2) == 0) ? CMD_PIXEL : CMD_DRAIN,
                pixel_t'($urandom));
    count += w * h + w + 1;
  endtask

  // Driver: present queued items in bursts, write registers only when nothing is in flight.
  always @(posedge clk) begin : drive_proc
    stim_op_t op;
    logic     hold, nxt_valid, nxt_wr;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      if (in_valid && !in_stall) blur_predict(in_cmd, pixel_t'({in_red, in_green, in_blue}));
      hold = in_valid && in_stall;
      nxt_valid = hold;
      nxt_wr = 1'b0;
      if (!in_valid && blur_q.size() == 0) quiet++;
      else quiet = 0;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          op = stim_q[0];
          case (op.kind)
            OP_TRANSFER: begin
              void'(stim_q.pop_front());
              nxt_valid = 1'b1;
              in_cmd <= op.cmd;
              in_red <= op.px.red;
              in_green <= op.px.green;
              in_blue <= op.px.blue;
              // close the burst and pick the next gap
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
            OP_REG_WRITE: begin
              if (quiet >= QUIET_CYCLES) begin
                void'(stim_q.pop_front());
                nxt_wr = 1'b1;
                cfg_index <= op.idx;
                cfg_wdata <= op.data;
                if (op.idx == REG_FRAME_WIDTH) width_reg = op.data;
                if (op.idx == REG_FRAME_HEIGHT) height_reg = op.data;
                // a size write restarts the frame
                if (op.idx == REG_FRAME_WIDTH || op.idx == REG_FRAME_HEIGHT) begin
                  in_col = 0;
                  in_row = 0;
                  out_col = 0;
                  out_row = 0;
                end
                gap_left = 1;
              end
            end
            default: begin
              if (quiet >= QUIET_CYCLES) void'(stim_q.pop_front());
            end
          endcase
        end
      end
      in_valid <= nxt_valid;
      cfg_wr_en <= nxt_wr;
    end
  end

  // Monitor: check each result transfer against the oldest expected pixel.
  always @(posedge clk) begin : check_proc
    blur_px_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (blur_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: rgb %0d %0d %0d last %0b",
                   out_red, out_green, out_blue, out_frame_last);
      end else begin
        want = blur_q.pop_front();
        if (out_red !== want.px.red || out_green !== want.px.green ||
            out_blue !== want.px.blue || out_frame_last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: expected rgb %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                     want.px.red, want.px.green, want.px.blue, want.last,
                     out_red, out_green, out_blue, out_frame_last);
        end
      end
    end
    // stall pattern: short alternating runs, now and then a long free stretch
    if (stall_run > 0) begin
      stall_run--;
    end else if (stall_now) begin
      stall_now = 1'b0;
      stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
    end else begin
      stall_now = 1'b1;
      stall_run = $urandom_range(0, 6);
    end
    out_stall <= stall_now;
  end

  initial begin
    logic [CFG_W-1:0] wv, hv;
    int               items, sel, n;
    items = 0;

    // 3x3 frame of mostly full-scale colours with an early drain, a pause and a
    // pixel arriving after the frame input is complete
    push_write(REG_FRAME_WIDTH, 11'd3);
    push_write(REG_FRAME_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) begin
      push_xfer(CMD_PIXEL, (i == 4) ? pixel_t'(24'hff007f) :
                           (i % 2) ? pixel_t'(24'hffffff) : pixel_t'(24'h000000));
      if (i == 3) push_xfer(CMD_DRAIN, pixel_t'(24'hffffff));
      if (i == 6) push_settle();
    end
    push_xfer(CMD_PIXEL, pixel_t'(24'h123456));
    repeat (3) push_xfer(CMD_DRAIN, pixel_t'(24'h000000));

    // zero sizes clamp to a single pixel
    push_write(REG_FRAME_WIDTH, 11'd0);
    push_write(REG_FRAME_HEIGHT, 11'd0);
    push_xfer(CMD_PIXEL, pixel_t'(24'hffffff));
    repeat (2) push_xfer(CMD_DRAIN, pixel_t'(24'h000000));

    // writes to spare indexes part way through a 2x2 frame
    push_write(REG_FRAME_WIDTH, 11'd2);
    push_write(REG_FRAME_HEIGHT, 11'd2);
    repeat (2) push_xfer(CMD_PIXEL, pick_pixel(FILL_RANDOM));
    push_write(REG_SPARE_A, 11'h7ff);
    push_write(REG_SPARE_B, 11'h000);
    repeat (2) push_xfer(CMD_PIXEL, pick_pixel(FILL_RANDOM));
    repeat (3) push_xfer(CMD_DRAIN, pixel_t'($urandom));

    // oversize registers clamp to the widest row and the tallest column;
    // the frame is left unfinished and the next size write restarts it
    push_write(REG_FRAME_WIDTH, 11'h7ff);
    push_write(REG_FRAME_HEIGHT, 11'h7ff);
    repeat (40) push_xfer(CMD_PIXEL, pick_pixel(FILL_RANDOM));
    push_xfer(CMD_DRAIN, pixel_t'($urandom));
    items += 41;

    // random frames, mostly small and well formed
    while (items < PIXEL_TARGET) begin
      sel = $urandom_range(0, 99);
      wv = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(9, 40))
                                       : CFG_W'($urandom_range(1, 8));
      hv = CFG_W'($urandom_range(1, 8));
      if (sel < 70) begin
        push_frame(wv, hv, fill_t'($urandom_range(0, 2)), 1'b0, items);
      end else if (sel < 90) begin
        push_frame(wv, hv, fill_t'($urandom_range(0, 2)), 1'b1, items);
      end else begin
        // abandon a frame part way; the next size write restarts it
        push_write(REG_FRAME_WIDTH, wv);
        push_write(REG_FRAME_HEIGHT, hv);
        n = $urandom_range(1, wv * hv);
        repeat (n) push_xfer(CMD_PIXEL, pick_pixel(FILL_RANDOM));
        items += n;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (blur_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && blur_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #6ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
